### hdl/gbtf_pkg.sv
// Shared types, constants and window classifier for the full-width text filter.
package gbtf_pkg;

  localparam int WIN_DEPTH   = 4;
  localparam int QUEUE_DEPTH = 2;

  // Code-range bounds.
  localparam logic [7:0] ROW_BASE    = 8'hA0;
  localparam logic [7:0] ASCII_LO    = 8'h21;
  localparam logic [7:0] ASCII_HI    = 8'h7E;
  localparam logic [7:0] FW_PREFIX   = 8'hA3;
  localparam logic [7:0] HIGH_BIT    = 8'h80;
  localparam logic [7:0] LEAD_LO     = 8'h81;
  localparam logic [7:0] LEAD_HI     = 8'hFE;
  localparam logic [7:0] HZ_LO       = 8'hB0;
  localparam logic [7:0] HZ_HI       = 8'hF7;
  localparam logic [7:0] TRAIL_A1    = 8'hA1;
  localparam logic [7:0] TRAIL_40    = 8'h40;
  localparam logic [7:0] LEAD_AA     = 8'hAA;
  localparam logic [7:0] Q_LEAD_HI1  = 8'h82;
  localparam logic [7:0] Q_LEAD_LO2  = 8'h95;
  localparam logic [7:0] Q_LEAD_HI2  = 8'h98;
  localparam logic [7:0] DIGIT_LO    = 8'h30;
  localparam logic [7:0] DIGIT_HI    = 8'h39;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [2:0] use_n;   // bytes consumed (before clamping to fill)
    logic       emit;    // two bytes produced
    logic [7:0] e0;
    logic [7:0] e1;
  } action_t;

  function automatic logic in_rng(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic action_t classify(logic [7:0] b0, logic [7:0] b1,
                                       logic [7:0] b2, logic [7:0] b3);
    action_t a;
    a.use_n = 3'd1;
    a.emit  = 1'b0;
    a.e0    = 8'h00;
    a.e1    = 8'h00;
    if ((in_rng(b0, ROW_BASE + 8'd1, ROW_BASE + 8'd9) ||
         in_rng(b0, ROW_BASE + 8'd16, ROW_BASE + 8'd87)) &&
        in_rng(b1, ROW_BASE + 8'd1, ROW_BASE + 8'd94)) begin
      a.use_n = 3'd2;
      a.emit  = 1'b1;
      a.e0    = b0;
      a.e1    = b1;
    end else if (in_rng(b0, ASCII_LO, ASCII_HI)) begin
      a.use_n = 3'd1;
      a.emit  = 1'b1;
      a.e0    = FW_PREFIX;
      a.e1    = b0 + HIGH_BIT;
    end else if ((in_rng(b0, HZ_LO, HZ_HI) && in_rng(b1, TRAIL_A1, LEAD_HI)) ||
                 (in_rng(b0, LEAD_LO, ROW_BASE) && in_rng(b1, TRAIL_40, LEAD_HI)) ||
                 (in_rng(b0, LEAD_AA, LEAD_HI) && in_rng(b1, TRAIL_40, ROW_BASE))) begin
      a.use_n = 3'd2;
    end else if ((in_rng(b0, LEAD_LO, Q_LEAD_HI1) || in_rng(b0, Q_LEAD_LO2, Q_LEAD_HI2)) &&
                 in_rng(b1, DIGIT_LO, DIGIT_HI) && in_rng(b2, LEAD_LO, LEAD_HI) &&
                 in_rng(b3, DIGIT_LO, DIGIT_HI)) begin
      a.use_n = 3'd4;
    end
    return a;
  endfunction

endpackage

### hdl/gbtf_front.sv
// Input side: accepts text bytes into a short request queue.
module gbtf_front #(
  parameter int QDEPTH = gbtf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // [7:0] in_byte
  input  logic           s_axis_tlast,   // text_end
  output logic           q_valid,
  input  logic           q_pop,
  output gbtf_pkg::item_t q_item
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  gbtf_pkg::item_t mem [QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   fill;
  logic            push;
  logic            pop;

  assign s_axis_tready = (fill != CW'(QDEPTH));
  assign q_valid       = (fill != '0);
  assign q_item        = mem[rptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{data: s_axis_tdata, last: s_axis_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/gbtf_back.sv
// Execution side: byte window, classify-and-act sequencer, output register.
module gbtf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  gbtf_pkg::item_t q_item,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tuser,   // byte_valid
  output logic            m_axis_tlast    // end_mark
);

  typedef enum logic [1:0] {ST_IDLE, ST_ACT, ST_EMIT2, ST_FIN} state_t;

  state_t            state;
  logic [7:0]        win [gbtf_pkg::WIN_DEPTH];
  logic [7:0]        win_next [gbtf_pkg::WIN_DEPTH];
  logic [7:0]        bm [gbtf_pkg::WIN_DEPTH];
  logic [2:0]        count;
  logic [2:0]        count_next;
  logic [2:0]        use_eff;
  logic              flushing;
  logic              pend_valid;
  logic [7:0]        pend_byte;
  logic [7:0]        e1;
  logic              out_free;
  logic              prod_en;
  logic [7:0]        prod_byte;
  logic              load_out;
  state_t            after_act;
  state_t            after_emit;
  gbtf_pkg::action_t act;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign q_pop    = (state == ST_IDLE);

  // Output register takes a new request this cycle.
  assign load_out = (prod_en && (!flushing || pend_valid)) || (state == ST_FIN && out_free);

  // Bytes past the fill read as zero (end-of-text padding).
  always_comb begin
    for (int i = 0; i < gbtf_pkg::WIN_DEPTH; i++) begin
      bm[i] = (3'(i) < count) ? win[i] : 8'h00;
    end
  end

  assign act        = gbtf_pkg::classify(bm[0], bm[1], bm[2], bm[3]);
  assign use_eff    = (act.use_n > count) ? count : act.use_n;
  assign count_next = count - use_eff;

  always_comb begin
    logic [3:0] idx;
    for (int i = 0; i < gbtf_pkg::WIN_DEPTH; i++) begin
      idx = 4'(i) + {1'b0, use_eff};
      win_next[i] = (idx < 4'(gbtf_pkg::WIN_DEPTH)) ? win[idx[1:0]] : 8'h00;
    end
  end

  always_comb begin
    if (flushing && count_next == '0) begin
      after_act = ST_FIN;
    end else if (flushing) begin
      after_act = ST_ACT;
    end else begin
      after_act = ST_IDLE;
    end
    if (flushing && count == '0) begin
      after_emit = ST_FIN;
    end else if (flushing) begin
      after_emit = ST_ACT;
    end else begin
      after_emit = ST_IDLE;
    end
  end

  always_comb begin
    prod_en   = 1'b0;
    prod_byte = act.e0;
    if (state == ST_ACT && out_free && act.emit) begin
      prod_en = 1'b1;
    end else if (state == ST_EMIT2 && out_free) begin
      prod_en   = 1'b1;
      prod_byte = e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      flushing      <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !load_out) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            win[count[1:0]] <= q_item.data;
            count           <= count + 1'b1;
            flushing        <= q_item.last;
            if (q_item.last || count == 3'(gbtf_pkg::WIN_DEPTH - 1)) begin
              state <= ST_ACT;
            end
          end
        end
        ST_ACT: begin
          if (out_free) begin
            win   <= win_next;
            count <= count_next;
            if (act.emit) begin
              e1    <= act.e1;
              state <= ST_EMIT2;
            end else begin
              state <= after_act;
            end
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            state <= after_emit;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pend_valid ? pend_byte : 8'h00;
            m_axis_tuser  <= pend_valid;
            m_axis_tlast  <= 1'b1;
            pend_valid    <= 1'b0;
            flushing      <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // During a flush one byte is held back so the last one can carry the end mark.
      if (prod_en) begin
        if (flushing) begin
          if (pend_valid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= pend_byte;
            m_axis_tuser  <= 1'b1;
            m_axis_tlast  <= 1'b0;
          end
          pend_byte  <= prod_byte;
          pend_valid <= 1'b1;
        end else begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= prod_byte;
          m_axis_tuser  <= 1'b1;
          m_axis_tlast  <= 1'b0;
        end
      end
    end
  end

endmodule

### hdl/gb_text_fullwidth_filter.sv
// Top level of the GB2312 half-width to full-width text filter.
// Text bytes enter one request at a time on the s_axis side, with tlast on the
// final byte of a text. Up to four bytes collect in a window; when it is full,
// one classification is done and one action taken, and at tlast the window is
// zero-padded and worked off until empty. A GB2312 full-width pair passes
// through, printable ASCII 0x21..0x7E becomes the pair 0xA3, byte+0x80, GB18030
// two- and four-byte codes are dropped whole, and any other byte is dropped
// alone. Each output request carries one byte in tdata; tuser is 1 when the
// byte is real data and 0 for a bare end marker, which appears only when the
// window worked off at tlast produced no bytes; tlast marks the last request
// of a text. A byte that does not fill the window is only stored in it; each
// classification step passes through ST_ACT, and through ST_EMIT2 as well
// when it emits a pair, and the output register moves one byte per cycle
// while the output is not stalled; the end of a flush passes through ST_FIN.
// A printable ASCII byte is consumed alone but emits a pair. A two-entry
// queue between front and back lets input be taken while the back end works
// or the output stalls.
module gb_text_fullwidth_filter #(
  parameter int QDEPTH = gbtf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // text_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // byte_valid
  output logic       m_axis_tlast    // end_mark
);

  logic            q_valid;
  logic            q_pop;
  gbtf_pkg::item_t q_item;

  gbtf_front #(.QDEPTH(QDEPTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  gbtf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
